[design/i2a_pkg.sv]
// Package for the integer to ASCII radix converter.
// Holds widths, the queue item type, back-end states and the digit table.
// No dependencies.
package i2a_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int CHAR_WIDTH  = 8;
   localparam int DEC_DIGITS  = 20;
   localparam int HEX_DIGITS  = VALUE_WIDTH / 4;
   localparam int BCD_WIDTH   = DEC_DIGITS * 4;
   localparam int COUNT_WIDTH = $clog2(DEC_DIGITS + 1);
   localparam int BIT_WIDTH   = $clog2(VALUE_WIDTH);
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;

   // classified item handed from the front end to the back end
   typedef struct packed {
      logic [VALUE_WIDTH-1:0] magnitude;
      logic                   negative;
      logic                   hex;
   } i2a_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_STRIP,
      ST_SIGN,
      ST_EMIT
   } i2a_state_type;

   // map one digit to its ASCII code, lower-case letters for hex
   function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [3:0] digit);
      logic [CHAR_WIDTH-1:0] code;
      if (digit < 4'd10) begin
         code = 8'h30 + {4'd0, digit};
      end else begin
         code = 8'h57 + {4'd0, digit};
      end
      return code;
   endfunction

endpackage

[design/i2a_front.sv]
// Front end of the integer to ASCII converter: accepts words and classifies them.
// Takes the magnitude and sign of signed decimal operands. Depends on i2a_pkg.
module i2a_front (
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [i2a_pkg::VALUE_WIDTH-1:0] value_bits,
   input  logic                           signed_mode,
   input  logic                           hex_mode,
   output logic                           push_valid,
   input  logic                           push_ready,
   output i2a_pkg::i2a_item_type          push_item
);
   import i2a_pkg::*;

   logic is_negative;

   // signed flag only counts in decimal mode
   assign is_negative = signed_mode & ~hex_mode & value_bits[VALUE_WIDTH-1];

   // negate as an unsigned quantity so the most negative value stays exact
   always_comb begin
      push_item.negative  = is_negative;
      push_item.hex       = hex_mode;
      push_item.magnitude = is_negative ? (~value_bits + 64'd1) : value_bits;
   end

   assign push_valid = req_tvalid;
   assign req_tready = push_ready;

endmodule

[design/i2a_queue.sv]
// Short queue between the front and back ends of the converter.
// Holds classified items so each side stalls on its own. Depends on i2a_pkg.
module i2a_queue #(
   parameter int Depth = i2a_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  i2a_pkg::i2a_item_type push_item,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output i2a_pkg::i2a_item_type pop_item
);
   import i2a_pkg::*;

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(Depth);

   i2a_item_type          entry_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != FullCnt);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   // advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed item
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[design/i2a_back.sv]
// Back end of the integer to ASCII converter: double-dabble BCD conversion,
// leading-zero strip and character emit through an output register. Depends on i2a_pkg.
module i2a_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           pop_valid,
   output logic                           pop_ready,
   input  i2a_pkg::i2a_item_type          pop_item,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [i2a_pkg::CHAR_WIDTH-1:0] char_code,
   output logic                           last_char
);
   import i2a_pkg::*;

   i2a_state_type           state_ff, state_in;
   logic [VALUE_WIDTH-1:0]  mag_ff;
   logic                    neg_ff;
   logic [BCD_WIDTH-1:0]    digits_ff;
   logic [BCD_WIDTH-1:0]    digits_adj;
   logic [COUNT_WIDTH-1:0]  count_ff;
   logic [BIT_WIDTH-1:0]    bit_ff;
   logic                    out_valid_ff;
   logic [CHAR_WIDTH-1:0]   out_char_ff;
   logic                    out_last_ff;

   logic [3:0] top_digit;
   logic       out_free;
   logic       top_zero;
   logic       one_left;
   logic       load, conv_step, strip_step, sign_emit, digit_emit;

   assign top_digit = digits_ff[BCD_WIDTH-1 -: 4];
   assign top_zero  = (top_digit == 4'd0);
   assign one_left  = (count_ff == COUNT_WIDTH'(1));
   assign out_free  = ~out_valid_ff | rsp_tready;

   // add three to every BCD digit of five or more before the shift
   always_comb begin
      for (int d = 0; d < DEC_DIGITS; d++) begin
         digits_adj[d*4 +: 4] = (digits_ff[d*4 +: 4] >= 4'd5) ?
                                digits_ff[d*4 +: 4] + 4'd3 : digits_ff[d*4 +: 4];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               state_in = pop_item.hex ? ST_STRIP : ST_CONV;
            end
         end
         ST_CONV: begin
            if (bit_ff == BIT_WIDTH'(VALUE_WIDTH - 1)) begin
               state_in = ST_STRIP;
            end
         end
         ST_STRIP: begin
            if (one_left || !top_zero) begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free && one_left) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      load       = 1'b0;
      conv_step  = 1'b0;
      strip_step = 1'b0;
      sign_emit  = 1'b0;
      digit_emit = 1'b0;
      unique case (state_ff)
         ST_IDLE:  load       = pop_valid;
         ST_CONV:  conv_step  = 1'b1;
         ST_STRIP: strip_step = top_zero & ~one_left;
         ST_SIGN:  sign_emit  = out_free;
         ST_EMIT:  digit_emit = out_free;
         default: ;
      endcase
   end

   assign pop_ready = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (sign_emit || digit_emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // datapath: load, shift-and-add, strip leading zeros, emit digits
   always_ff @(posedge clock) begin
      if (load) begin
         neg_ff <= pop_item.negative;
         mag_ff <= pop_item.magnitude;
         bit_ff <= '0;
         if (pop_item.hex) begin
            digits_ff <= {pop_item.magnitude, {(BCD_WIDTH - VALUE_WIDTH){1'b0}}};
            count_ff  <= COUNT_WIDTH'(HEX_DIGITS);
         end else begin
            digits_ff <= '0;
            count_ff  <= COUNT_WIDTH'(DEC_DIGITS);
         end
      end else if (conv_step) begin
         digits_ff <= {digits_adj[BCD_WIDTH-2:0], mag_ff[VALUE_WIDTH-1]};
         mag_ff    <= {mag_ff[VALUE_WIDTH-2:0], 1'b0};
         bit_ff    <= bit_ff + 1'b1;
      end else if (strip_step || digit_emit) begin
         digits_ff <= {digits_ff[BCD_WIDTH-5:0], 4'd0};
         count_ff  <= count_ff - 1'b1;
      end
   end

   // hold the character until the sink takes it
   always_ff @(posedge clock) begin
      if (sign_emit) begin
         out_char_ff <= CHAR_MINUS;
         out_last_ff <= 1'b0;
      end else if (digit_emit) begin
         out_char_ff <= digit_char(top_digit);
         out_last_ff <= one_left;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign char_code  = out_char_ff;
   assign last_char  = out_last_ff;

endmodule

[design/integer_to_ascii_radix_core.sv]
// Top level of the integer to ASCII radix converter.
// Instantiates i2a_front, i2a_queue and i2a_back; depends on i2a_pkg.
//
//   channel  | direction | tdata               | tuser / tlast
//   req_     | in        | value_bits[63:0]    | tuser: signed_mode, hex_mode
//   rsp_     | out       | char_code[7:0]      | tlast: last_char
//
// Decimal items are loaded, run through the shift-and-add BCD loop, then have
// leading zeros stripped and are emitted a character at a time while the sink
// is ready; hex items skip the loop and go straight to the strip.
// Reset is synchronous, active high, and empties the queue and output register.
// While it has room the queue takes new words as the back end works; a stalled rsp_
// side holds the output register and back end, and the front end on a full queue.
module integer_to_ascii_radix_core #(
   parameter int QueueDepth = i2a_pkg::QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [i2a_pkg::VALUE_WIDTH-1:0] req_tdata,  // value_bits[63:0]
   input  logic [1:0]                     req_tuser,  // [0] signed_mode, [1] hex_mode
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [i2a_pkg::CHAR_WIDTH-1:0] rsp_tdata,  // char_code[7:0]
   output logic                           rsp_tlast
);
   import i2a_pkg::*;

   logic         push_valid, push_ready;
   logic         pop_valid, pop_ready;
   i2a_item_type push_item, pop_item;

   i2a_front u_front (
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .value_bits  (req_tdata),
      .signed_mode (req_tuser[0]),
      .hex_mode    (req_tuser[1]),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_item   (push_item)
   );

   i2a_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   i2a_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .char_code  (rsp_tdata),
      .last_char  (rsp_tlast)
   );

endmodule
